@@ rtl/ritoa_pkg.sv @@
package ritoa_pkg;

  localparam int MAGNITUDE_BITS_DEF = 32;
  localparam int VALUE_W            = 33;
  localparam int BASE_W             = 5;
  localparam int CHAR_W             = 7;
  localparam int LEN_W              = 6;
  localparam int DIGIT_W            = 4;
  localparam int DIV_STEP           = 8;

  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
  localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;

  typedef struct packed {
    logic              bad_base;
    logic              negative;
    logic              uppercase;
    logic [BASE_W-1:0] base;
  } item_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT,
    ST_BAD
  } back_state_t;

endpackage

@@ rtl/ritoa_front.sv @@
module ritoa_front #(
  parameter int MAG_W = ritoa_pkg::MAGNITUDE_BITS_DEF
) (
  input  logic signed [ritoa_pkg::VALUE_W-1:0] value,
  input  logic        [ritoa_pkg::BASE_W-1:0]  base,
  input  logic                                 uppercase,
  output ritoa_pkg::item_ctrl_t                ctrl,
  output logic        [MAG_W-1:0]              mag
);

  logic [ritoa_pkg::VALUE_W-1:0] raw;
  logic [ritoa_pkg::VALUE_W-1:0] abs_val;
  logic                          too_wide;

  assign raw      = $unsigned(value);
  assign abs_val  = raw[ritoa_pkg::VALUE_W-1] ? (~raw + ritoa_pkg::VALUE_W'(1)) : raw;
  assign too_wide = |(abs_val >> MAG_W);
  assign mag      = too_wide ? {MAG_W{1'b1}} : abs_val[MAG_W-1:0];

  always_comb begin
    ctrl.bad_base  = (base < ritoa_pkg::BASE_MIN) || (base > ritoa_pkg::BASE_MAX);
    ctrl.negative  = raw[ritoa_pkg::VALUE_W-1];
    ctrl.uppercase = uppercase;
    ctrl.base      = base;
  end

endmodule

@@ rtl/ritoa_queue.sv @@
module ritoa_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/ritoa_div.sv @@
module ritoa_div #(
  parameter int MAG_W = ritoa_pkg::MAGNITUDE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [MAG_W-1:0]                   dividend,
  input  logic [ritoa_pkg::BASE_W-1:0]       divisor,
  output logic                               done,
  output logic [MAG_W-1:0]                   quotient,
  output logic [ritoa_pkg::DIGIT_W-1:0]      remainder
);

  localparam int ITERS = (MAG_W + ritoa_pkg::DIV_STEP - 1) / ritoa_pkg::DIV_STEP;
  localparam int PAD_W = ITERS * ritoa_pkg::DIV_STEP;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic [PAD_W-1:0]                  work;
  logic [PAD_W-1:0]                  work_next;
  logic [ritoa_pkg::DIGIT_W-1:0]     rem;
  logic [ritoa_pkg::DIGIT_W-1:0]     rem_next;
  logic [ritoa_pkg::BASE_W-1:0]      dsr;
  logic [CNT_W-1:0]                  cnt;
  logic                              busy;

  // restoring division, DIV_STEP quotient bits per cycle
  always_comb begin
    logic [ritoa_pkg::BASE_W-1:0] r5;
    work_next = work;
    rem_next  = rem;
    for (int j = 0; j < ritoa_pkg::DIV_STEP; j++) begin
      r5        = {rem_next, work_next[PAD_W-1]};
      work_next = {work_next[PAD_W-2:0], 1'b0};
      if (r5 >= dsr) begin
        r5           = r5 - dsr;
        work_next[0] = 1'b1;
      end
      rem_next = r5[ritoa_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= PAD_W'(dividend);
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ITERS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = work[MAG_W-1:0];
  assign remainder = rem;

endmodule

@@ rtl/ritoa_back.sv @@
module ritoa_back #(
  parameter int MAG_W = ritoa_pkg::MAGNITUDE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  ritoa_pkg::item_ctrl_t          ctrl,
  input  logic [MAG_W-1:0]               mag,
  output logic                           div_start,
  output logic [MAG_W-1:0]               div_dividend,
  output logic [ritoa_pkg::BASE_W-1:0]   div_divisor,
  input  logic                           div_done,
  input  logic [MAG_W-1:0]               div_quotient,
  input  logic [ritoa_pkg::DIGIT_W-1:0]  div_remainder,
  output logic                           char_valid,
  input  logic                           char_ready,
  output logic [ritoa_pkg::CHAR_W-1:0]   character,
  output logic                           last,
  output logic                           bad_base,
  output logic [ritoa_pkg::LEN_W-1:0]    length
);

  localparam int IDX_W = $clog2(MAG_W);

  ritoa_pkg::back_state_t            state;
  ritoa_pkg::back_state_t            state_next;
  ritoa_pkg::item_ctrl_t             ctrl_r;
  logic [ritoa_pkg::LEN_W-1:0]       n;
  logic [ritoa_pkg::LEN_W-1:0]       n_next;
  logic [IDX_W-1:0]                  idx;
  logic [IDX_W-1:0]                  idx_next;
  logic [ritoa_pkg::DIGIT_W-1:0]     digit_store [MAG_W];
  logic [ritoa_pkg::DIGIT_W-1:0]     rd_data;
  logic                              store_we;
  logic                              out_free;
  logic                              out_load;
  logic [ritoa_pkg::CHAR_W-1:0]      char_next;
  logic                              last_next;
  logic                              bad_next;
  logic [ritoa_pkg::LEN_W-1:0]       length_next;
  logic [ritoa_pkg::LEN_W-1:0]       total;

  function automatic logic [ritoa_pkg::CHAR_W-1:0] ascii_of_digit(
    input logic [ritoa_pkg::DIGIT_W-1:0] d,
    input logic [ritoa_pkg::BASE_W-1:0]  radix,
    input logic                          upper
  );
    logic [ritoa_pkg::CHAR_W-1:0] dx;
    dx = ritoa_pkg::CHAR_W'(d);
    if (d < 4'd10) begin
      return ritoa_pkg::CHAR_ZERO + dx;
    end else if (radix == ritoa_pkg::BASE_HEX && !upper) begin
      return ritoa_pkg::CHAR_LOWER_A + dx - 7'd10;
    end
    return ritoa_pkg::CHAR_UPPER_A + dx - 7'd10;
  endfunction

  assign out_free     = !char_valid || char_ready;
  assign total        = n + ritoa_pkg::LEN_W'(ctrl_r.negative);
  assign div_dividend = (state == ritoa_pkg::ST_IDLE) ? mag : div_quotient;
  assign div_divisor  = (state == ritoa_pkg::ST_IDLE) ? ctrl.base : ctrl_r.base;

  always_comb begin
    state_next  = state;
    n_next      = n;
    idx_next    = idx;
    pop_ready   = 1'b0;
    div_start   = 1'b0;
    store_we    = 1'b0;
    out_load    = 1'b0;
    char_next   = ritoa_pkg::CHAR_NONE;
    last_next   = 1'b0;
    bad_next    = 1'b0;
    length_next = '0;
    unique case (state)
      ritoa_pkg::ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (ctrl.bad_base) begin
            state_next = ritoa_pkg::ST_BAD;
          end else begin
            div_start  = 1'b1;
            n_next     = '0;
            state_next = ritoa_pkg::ST_DIV;
          end
        end
      end
      ritoa_pkg::ST_DIV: begin
        if (div_done) begin
          store_we = 1'b1;
          n_next   = n + ritoa_pkg::LEN_W'(1);
          if (div_quotient == '0 || n_next == ritoa_pkg::LEN_W'(MAG_W)) begin
            state_next = ritoa_pkg::ST_SIGN;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ritoa_pkg::ST_SIGN: begin
        idx_next = IDX_W'(n - ritoa_pkg::LEN_W'(1));
        if (!ctrl_r.negative) begin
          state_next = ritoa_pkg::ST_READ;
        end else if (out_free) begin
          out_load   = 1'b1;
          char_next  = ritoa_pkg::CHAR_MINUS;
          state_next = ritoa_pkg::ST_READ;
        end
      end
      ritoa_pkg::ST_READ: begin
        state_next = ritoa_pkg::ST_EMIT;
      end
      ritoa_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          char_next = ascii_of_digit(rd_data, ctrl_r.base, ctrl_r.uppercase);
          if (idx == '0) begin
            last_next   = 1'b1;
            length_next = total;
            state_next  = ritoa_pkg::ST_IDLE;
          end else begin
            idx_next   = idx - IDX_W'(1);
            state_next = ritoa_pkg::ST_READ;
          end
        end
      end
      ritoa_pkg::ST_BAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          last_next  = 1'b1;
          bad_next   = 1'b1;
          state_next = ritoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ritoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ritoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      digit_store[n[IDX_W-1:0]] <= div_remainder;
    end
    rd_data <= digit_store[idx];
  end

  always_ff @(posedge clk) begin
    n   <= n_next;
    idx <= idx_next;
    if (pop_valid && pop_ready) begin
      ctrl_r <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (out_load) begin
      char_valid <= 1'b1;
    end else if (char_ready) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      character <= char_next;
      last      <= last_next;
      bad_base  <= bad_next;
      length    <= length_next;
    end
  end

endmodule

@@ rtl/radix_integer_to_ascii_core.sv @@
// channel     | handshake               | payload
// ------------+-------------------------+-----------------------------------
// item in     | item_valid / item_ready | value[32:0], base[4:0], uppercase
// char out    | char_valid / char_ready | character[6:0], last, bad_base,
//             |                         | length[5:0]
//
// per digit: one division in the shared divider on W = min(MAGNITUDE_BITS, 33) bits
// per character: ST_READ through the registered digit store read port, then ST_EMIT
// a bad base gives one transaction
// reset: rst synchronous, clears queue, sequencer and output valid
// a two-entry queue takes new items while the back end converts or stalls on char_ready
module radix_integer_to_ascii_core #(
  parameter int MAGNITUDE_BITS = ritoa_pkg::MAGNITUDE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic signed [ritoa_pkg::VALUE_W-1:0] value,
  input  logic        [ritoa_pkg::BASE_W-1:0]  base,
  input  logic                                 uppercase,
  output logic                                 char_valid,
  input  logic                                 char_ready,
  output logic        [ritoa_pkg::CHAR_W-1:0]  character,
  output logic                                 last,
  output logic                                 bad_base,
  output logic        [ritoa_pkg::LEN_W-1:0]   length
);

  localparam int MAG_W = (MAGNITUDE_BITS < ritoa_pkg::VALUE_W) ? MAGNITUDE_BITS
                                                               : ritoa_pkg::VALUE_W;
  localparam int CTRL_W = $bits(ritoa_pkg::item_ctrl_t);
  localparam int Q_W    = CTRL_W + MAG_W;

  ritoa_pkg::item_ctrl_t               f_ctrl;
  logic [MAG_W-1:0]                    f_mag;
  logic [Q_W-1:0]                      q_head;
  logic                                q_valid;
  logic                                q_ready;
  ritoa_pkg::item_ctrl_t               b_ctrl;
  logic [MAG_W-1:0]                    b_mag;
  logic                                div_start;
  logic [MAG_W-1:0]                    div_dividend;
  logic [ritoa_pkg::BASE_W-1:0]        div_divisor;
  logic                                div_done;
  logic [MAG_W-1:0]                    div_quotient;
  logic [ritoa_pkg::DIGIT_W-1:0]       div_remainder;

  ritoa_front #(.MAG_W(MAG_W)) u_front (
    .value     (value),
    .base      (base),
    .uppercase (uppercase),
    .ctrl      (f_ctrl),
    .mag       (f_mag)
  );

  ritoa_queue #(.W(Q_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (item_valid),
    .push_ready (item_ready),
    .push_data  ({f_ctrl, f_mag}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_head)
  );

  assign b_ctrl = q_head[Q_W-1:MAG_W];
  assign b_mag  = q_head[MAG_W-1:0];

  ritoa_div #(.MAG_W(MAG_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  ritoa_back #(.MAG_W(MAG_W)) u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (q_valid),
    .pop_ready     (q_ready),
    .ctrl          (b_ctrl),
    .mag           (b_mag),
    .div_start     (div_start),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_done      (div_done),
    .div_quotient  (div_quotient),
    .div_remainder (div_remainder),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .character     (character),
    .last          (last),
    .bad_base      (bad_base),
    .length        (length)
  );

endmodule

@@ rtl/ritoa_checker.sv @@
module ritoa_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 char_valid,
  input logic                                 char_ready,
  input logic        [ritoa_pkg::CHAR_W-1:0]  character,
  input logic                                 last,
  input logic                                 bad_base,
  input logic        [ritoa_pkg::LEN_W-1:0]   length
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(character) && $stable(last)
      && $stable(bad_base) && $stable(length))
    else $error("output transaction changed while stalled");

  a_bad_form: assert property (@(posedge clk) disable iff (rst)
    char_valid && bad_base |-> last && character == ritoa_pkg::CHAR_NONE && length == '0)
    else $error("malformed bad base transaction");

  a_len_mid: assert property (@(posedge clk) disable iff (rst)
    char_valid && !last |-> length == '0 && !bad_base)
    else $error("length set before last transaction");

  a_len_last: assert property (@(posedge clk) disable iff (rst)
    char_valid && last && !bad_base |-> length != '0 && character != ritoa_pkg::CHAR_MINUS)
    else $error("bad final transaction of a conversion");

endmodule

bind radix_integer_to_ascii_core ritoa_checker u_ritoa_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .character  (character),
  .last       (last),
  .bad_base   (bad_base),
  .length     (length)
);

@@ tb/radix_integer_to_ascii_checker.sv @@
`timescale 1ns / 1ps

module radix_integer_to_ascii_checker #(
  parameter int MAG_BITS = ritoa_pkg::MAGNITUDE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  input  logic                                 item_ready,
  input  logic signed [ritoa_pkg::VALUE_W-1:0] value,
  input  logic        [ritoa_pkg::BASE_W-1:0]  base,
  input  logic                                 uppercase,
  input  logic                                 char_valid,
  input  logic                                 char_ready,
  input  logic        [ritoa_pkg::CHAR_W-1:0]  character,
  input  logic                                 last,
  input  logic                                 bad_base,
  input  logic        [ritoa_pkg::LEN_W-1:0]   length,
  output int                                   fail_count,
  output int                                   outstanding
);

  typedef struct packed {
    logic [ritoa_pkg::CHAR_W-1:0] character;
    logic                         last;
    logic                         bad_base;
    logic [ritoa_pkg::LEN_W-1:0]  length;
  } ascii_char_t;

  ascii_char_t expected_chars[$];
  int          mismatches = 0;

  // expected characters of one conversion, most significant digit first
  function automatic void predict_conversion(input logic [ritoa_pkg::VALUE_W-1:0] raw,
                                             input logic [ritoa_pkg::BASE_W-1:0] radix,
                                             input logic upper);
    logic [ritoa_pkg::VALUE_W-1:0] abs_val;
    logic [63:0]                   mag;
    logic [63:0]                   cap;
    logic [63:0]                   rem;
    logic [3:0]                    digs[0:63];
    logic [3:0]                    d;
    logic [ritoa_pkg::LEN_W-1:0]   total_len;
    logic                          neg;
    int                            n;
    int                            total;
    ascii_char_t                   r;
    if (radix < ritoa_pkg::BASE_MIN || radix > ritoa_pkg::BASE_MAX) begin
      r.character = ritoa_pkg::CHAR_NONE;
      r.last      = 1'b1;
      r.bad_base  = 1'b1;
      r.length    = '0;
      expected_chars.push_back(r);
      return;
    end
    neg     = raw[ritoa_pkg::VALUE_W-1];
    abs_val = neg ? ({ritoa_pkg::VALUE_W{1'b0}} - raw) : raw;
    mag     = {{(64-ritoa_pkg::VALUE_W){1'b0}}, abs_val};
    cap     = (64'd1 << MAG_BITS) - 64'd1;
    if (mag > cap)
      mag = cap;
    // digits gathered least significant first
    n = 0;
    do begin
      rem = mag % {59'd0, radix};
      if (n < MAG_BITS)
        digs[n] = rem[3:0];
      n++;
      mag = mag / {59'd0, radix};
    end while (mag != 64'd0 && n < MAG_BITS);
    total     = n + (neg ? 1 : 0);
    total_len = total[ritoa_pkg::LEN_W-1:0];
    if (neg) begin
      r.character = ritoa_pkg::CHAR_MINUS;
      r.last      = (total == 1);
      r.bad_base  = 1'b0;
      r.length    = '0;
      expected_chars.push_back(r);
    end
    for (int i = n; i > 0; i--) begin
      d = digs[i-1];
      if (d < 4'd10)
        r.character = ritoa_pkg::CHAR_ZERO + {3'b000, d};
      else if (radix == ritoa_pkg::BASE_HEX && !upper)
        r.character = ritoa_pkg::CHAR_LOWER_A + {3'b000, d} - 7'd10;
      else
        r.character = ritoa_pkg::CHAR_UPPER_A + {3'b000, d} - 7'd10;
      r.last     = (i == 1);
      r.bad_base = 1'b0;
      r.length   = (i == 1) ? total_len : '0;
      expected_chars.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : watch
    ascii_char_t want;
    if (!rst) begin
      // compare before queuing: a transaction never belongs to an item taken at the same edge
      if (char_valid && char_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected transaction: character %0h last %0b bad_base %0b length %0d",
                 character, last, bad_base, length);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (character !== want.character) begin
            $error("character: expected %0h actual %0h", want.character, character);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b actual %0b", want.last, last);
            mismatches++;
          end
          if (bad_base !== want.bad_base) begin
            $error("bad_base: expected %0b actual %0b", want.bad_base, bad_base);
            mismatches++;
          end
          if (length !== want.length) begin
            $error("length: expected %0d actual %0d", want.length, length);
            mismatches++;
          end
        end
      end
      if (item_valid && item_ready)
        predict_conversion(value, base, uppercase);
    end
    fail_count  <= mismatches;
    outstanding <= expected_chars.size();
  end

endmodule

@@ tb/radix_integer_to_ascii_core_tb.sv @@
`timescale 1ns / 1ps

module radix_integer_to_ascii_core_tb;

  logic                                 clk        = 1'b0;
  logic                                 rst        = 1'b1;
  logic                                 item_valid = 1'b0;
  logic                                 item_ready;
  logic signed [ritoa_pkg::VALUE_W-1:0] value      = '0;
  logic        [ritoa_pkg::BASE_W-1:0]  base       = '0;
  logic                                 uppercase  = 1'b0;
  logic                                 char_valid;
  logic                                 char_ready = 1'b0;
  logic        [ritoa_pkg::CHAR_W-1:0]  character;
  logic                                 last;
  logic                                 bad_base;
  logic        [ritoa_pkg::LEN_W-1:0]   length;
  int                                   fail_count;
  int                                   outstanding;
  bit                                   calm_src   = 1'b0;
  bit                                   calm_snk   = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  radix_integer_to_ascii_core u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .value      (value),
    .base       (base),
    .uppercase  (uppercase),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .character  (character),
    .last       (last),
    .bad_base   (bad_base),
    .length     (length)
  );

  radix_integer_to_ascii_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .value       (value),
    .base        (base),
    .uppercase   (uppercase),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .character   (character),
    .last        (last),
    .bad_base    (bad_base),
    .length      (length),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic send_item(input logic [ritoa_pkg::VALUE_W-1:0] v,
                           input logic [ritoa_pkg::BASE_W-1:0] b,
                           input logic u);
    int gap;
    gap = calm_src ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    base       <= b;
    uppercase  <= u;
    do @(posedge clk); while (!item_ready);
  endtask

  // hold off new items until every expected transaction has come back
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : sink_side
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm_snk ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        char_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      char_ready <= 1'b1;
      do @(posedge clk); while (!char_valid);
    end
  end

  initial begin : stimulus
    logic [ritoa_pkg::VALUE_W-1:0] v;
    logic [ritoa_pkg::BASE_W-1:0]  b;
    logic                          u;
    int                            r;
    int                            mode;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(33'h0_0000_0000, 5'd10, 1'b0);
    send_item(33'h0_0000_0001, ritoa_pkg::BASE_MIN, 1'b0);
    send_item(33'h1_FFFF_FFFF, 5'd10, 1'b0);
    send_item(33'h0_FFFF_FFFF, ritoa_pkg::BASE_MIN, 1'b0);
    send_item(33'h0_FFFF_FFFF, ritoa_pkg::BASE_HEX, 1'b0);
    send_item(33'h0_FFFF_FFFF, ritoa_pkg::BASE_HEX, 1'b1);
    send_item(33'h1_0000_0000, ritoa_pkg::BASE_MIN, 1'b1);
    send_item(33'h1_0000_0001, ritoa_pkg::BASE_HEX, 1'b0);
    send_item(33'h1_8000_0000, 5'd10, 1'b0);
    send_item(33'h0_7FFF_FFFF, 5'd8, 1'b0);
    send_item(33'h0_8000_0000, 5'd3, 1'b1);
    send_item(33'h0_0000_0005, 5'd0, 1'b0);
    send_item(33'h1_FFFF_FFF9, 5'd1, 1'b1);
    send_item(33'h0_0000_0063, 5'd17, 1'b0);
    send_item(33'h1_2345_6789, 5'd31, 1'b1);
    send_item(33'h0_00AB_CDEF, ritoa_pkg::BASE_HEX, 1'b0);
    send_item(33'h1_FF54_3211, ritoa_pkg::BASE_HEX, 1'b1);
    send_item(33'h0_0000_DEAD, 5'd15, 1'b0);
    send_item(33'h0_0000_00C2, 5'd14, 1'b0);
    send_item(33'h0_FFFF_FFFF, 5'd13, 1'b1);
    send_item(33'h1_FFFF_FFF6, 5'd10, 1'b1);
    send_item(33'h0_075B_CD15, 5'd7, 1'b0);
    send_item(33'h0_0000_0078, 5'd11, 1'b0);
    send_item(33'h1_FFFF_FFF5, 5'd12, 1'b1);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      calm_snk = (phase == 1) || (phase == 2);
      calm_src = (phase == 2);
      for (int k = 0; k < 109; k++) begin
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
          r           = $urandom();
          v[31:0]     = r;
          r           = $urandom();
          v[ritoa_pkg::VALUE_W-1] = r[0];
        end else if (mode < 6) begin
          r = $urandom_range(0, 40);
          v = {1'b0, r[31:0]};
          if ($urandom_range(0, 1) == 1)
            v = {ritoa_pkg::VALUE_W{1'b0}} - v;
        end else if (mode == 6) begin
          case ($urandom_range(0, 8))
            0: v = 33'h0_0000_0000;
            1: v = 33'h0_0000_0001;
            2: v = 33'h1_FFFF_FFFF;
            3: v = 33'h0_FFFF_FFFF;
            4: v = 33'h1_0000_0000;
            5: v = 33'h1_0000_0001;
            6: v = 33'h0_8000_0000;
            7: v = 33'h1_8000_0000;
            default: v = 33'h0_7FFF_FFFF;
          endcase
        end else begin
          r = $urandom();
          v = {r[31], r[31:0]};
        end
        if ($urandom_range(0, 4) == 0)
          r = $urandom_range(0, 31);
        else
          r = $urandom_range(2, 16);
        b = r[ritoa_pkg::BASE_W-1:0];
        r = $urandom();
        u = r[0];
        send_item(v, b, u);
      end
      drain_results();
    end

    repeat (250) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("radix_integer_to_ascii_core verification clean");
    else
      $display("radix_integer_to_ascii_core verification failed");
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("radix_integer_to_ascii_core verification failed");
    $finish;
  end

endmodule
